>>> rtl/crm_pkg.sv
`timescale 1ns / 1ps
// crm_pkg: shared constants and types for the cyclic rotation matcher.
// No dependencies; used by the interfaces, the cell and the top level.
package crm_pkg;

  localparam int MAX_LEN = 64;
  localparam int ELEM_W  = 32;   // stored/compared bits of each element
  localparam int DATA_W  = 32;   // payload width of one element
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int OFS_W   = 7;

  localparam logic [OFS_W-1:0] NO_MATCH = {OFS_W{1'b1}};  // -1

  typedef logic [ELEM_W-1:0] elem_t;

  // broadcast controls for the cell row
  typedef struct packed {
    logic shift;   // rotate reference ring by one
  } cell_ctrl_t;

endpackage

>>> rtl/crm_if.sv
`timescale 1ns / 1ps
// Channel interfaces for the cyclic rotation matcher (input pairs, results).
// Depends on crm_pkg.
interface crm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [crm_pkg::DATA_W-1:0]   elem_a;
  logic signed [crm_pkg::DATA_W-1:0]   elem_b;
  logic                                last_pair;

  modport source (output valid, elem_a, elem_b, last_pair, input ready);
  modport sink   (input valid, elem_a, elem_b, last_pair, output ready);
endinterface

interface crm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [crm_pkg::OFS_W-1:0]  shift_offset;
  logic                              overflowed;

  modport source (output valid, shift_offset, overflowed, input ready);
  modport sink   (input valid, shift_offset, overflowed, output ready);
endinterface

>>> rtl/crm_cell.sv
`timescale 1ns / 1ps
// crm_cell: one position of the sequence pair. Holds a reference element that
// rotates through the ring and a fixed candidate element. Depends on crm_pkg.
module crm_cell (
  input  logic                clk,
  input  crm_pkg::cell_ctrl_t ctrl,
  input  logic                load_en,
  input  crm_pkg::elem_t      a_in,
  input  crm_pkg::elem_t      b_in,
  input  crm_pkg::elem_t      nbr_a,    // from the next cell up
  input  crm_pkg::elem_t      wrap_a,   // from cell 0, used by the tail cell
  input  logic                is_tail,
  input  logic                active,
  output crm_pkg::elem_t      a_out,
  output logic                match
);

  crm_pkg::elem_t a_r, a_nxt;
  crm_pkg::elem_t b_r, b_nxt;

  always_comb begin
    a_nxt = a_r;
    b_nxt = b_r;
    if (load_en) begin
      a_nxt = a_in;
      b_nxt = b_in;
    end else if (ctrl.shift) begin
      a_nxt = is_tail ? wrap_a : nbr_a;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign a_out = a_r;
  // positions beyond the current length do not take part
  assign match = !active || (a_r == b_r);

endmodule

>>> rtl/cyclic_rotation_matcher_core.sv
`timescale 1ns / 1ps
// cyclic_rotation_matcher_core: top level, control and the ring of cells.
// Depends on crm_pkg, crm_if (crm_in_if, crm_out_if) and crm_cell.
//
// Pairs load at one per cycle into a row of MAX_LEN cells. The item marked
// last_pair starts the search: the reference ring rotates one position per
// cycle and all cells compare in parallel; the search stops at the first
// matching offset k, or at offset len-1 when nothing matches (len = pairs held,
// at most MAX_LEN). No input is taken during the search; the result sits in an
// output register while the next sequence loads. Pairs beyond MAX_LEN are
// dropped and reported through overflowed. Offset -1 reads as all ones.
module cyclic_rotation_matcher_core (
  input  logic              clk,
  input  logic              rst_n,
  crm_in_if.sink            in_ch,
  crm_out_if.source         out_ch
);

  typedef enum logic {ST_LOAD, ST_SEARCH} state_t;

  state_t                      state_r, state_nxt;
  logic [crm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        ovf_r, ovf_nxt;
  logic [crm_pkg::IDX_W-1:0]   k_r, k_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [crm_pkg::OFS_W-1:0]   out_ofs_r, out_ofs_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  crm_pkg::cell_ctrl_t         ctrl;
  logic                        in_acc, room, load, all_match, at_end, slot_free;
  crm_pkg::elem_t              a_row [crm_pkg::MAX_LEN];
  logic [crm_pkg::MAX_LEN-1:0] match_row;

  assign in_ch.ready = (state_r == ST_LOAD);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign room        = (cnt_r < crm_pkg::CNT_W'(crm_pkg::MAX_LEN));
  assign load        = in_acc && room;
  assign all_match   = &match_row;
  assign at_end      = ({{(crm_pkg::CNT_W - crm_pkg::IDX_W){1'b0}}, k_r}
                        + crm_pkg::CNT_W'(1)) == cnt_r;
  assign slot_free   = !out_valid_r || out_ch.ready;

  for (genvar i = 0; i < crm_pkg::MAX_LEN; i++) begin : g_cell
    crm_cell u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .load_en (load && (cnt_r == crm_pkg::CNT_W'(i))),
      .a_in    (in_ch.elem_a[crm_pkg::ELEM_W-1:0]),
      .b_in    (in_ch.elem_b[crm_pkg::ELEM_W-1:0]),
      .nbr_a   (a_row[(i + 1) % crm_pkg::MAX_LEN]),
      .wrap_a  (a_row[0]),
      .is_tail (cnt_r == crm_pkg::CNT_W'(i + 1)),
      .active  (crm_pkg::CNT_W'(i) < cnt_r),
      .a_out   (a_row[i]),
      .match   (match_row[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ofs_nxt   = out_ofs_r;
    out_ovf_nxt   = out_ovf_r;
    ctrl.shift    = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) cnt_nxt = cnt_r + crm_pkg::CNT_W'(1);
          else      ovf_nxt = 1'b1;
          if (in_ch.last_pair) begin
            state_nxt = ST_SEARCH;
            k_nxt     = '0;
          end
        end
      end
      ST_SEARCH: begin
        if (all_match || at_end) begin
          if (slot_free) begin
            out_valid_nxt = 1'b1;
            out_ofs_nxt   = all_match ? crm_pkg::OFS_W'(k_r) : crm_pkg::NO_MATCH;
            out_ovf_nxt   = ovf_r;
            cnt_nxt       = '0;
            ovf_nxt       = 1'b0;
            state_nxt     = ST_LOAD;
          end
        end else begin
          ctrl.shift = 1'b1;
          k_nxt      = k_r + crm_pkg::IDX_W'(1);
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_ofs_r <= out_ofs_nxt;
    out_ovf_r <= out_ovf_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.shift_offset = out_ofs_r;
  assign out_ch.overflowed   = out_ovf_r;

  // the offset under test never reaches the sequence length
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> {{(crm_pkg::CNT_W - crm_pkg::IDX_W){1'b0}}, k_r} < cnt_r)
    else $error("search offset beyond sequence length");

  // a result only appears at the end of a search
  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_SEARCH) && state_r == ST_LOAD)
    else $error("result without a finished search");

  // a search never starts with an empty ring
  a_search_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> cnt_r != '0 &&
                            cnt_r <= crm_pkg::CNT_W'(crm_pkg::MAX_LEN))
    else $error("bad length during search");

endmodule

>>> sim/tb_cyclic_rotation_matcher_core.sv
`timescale 1ns / 1ps
// Testbench for cyclic_rotation_matcher_core: random and directed pair sequences,
// results checked against a cycle-free predictor of the rotation search.
// Depends on crm_pkg, crm_if and the core itself.
module tb_cyclic_rotation_matcher_core;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam int DRAIN_CYCLES   = 100;

  localparam logic [crm_pkg::DATA_W-1:0] ELEM_MIN = {1'b1, {(crm_pkg::DATA_W-1){1'b0}}};
  localparam logic [crm_pkg::DATA_W-1:0] ELEM_MAX = {1'b0, {(crm_pkg::DATA_W-1){1'b1}}};

  // kinds of generated sequences
  typedef enum int {
    SEQ_ROTATED,
    SEQ_CORRUPTED,
    SEQ_UNRELATED
  } seq_kind_t;

  typedef struct packed {
    logic [crm_pkg::OFS_W-1:0] shift_offset;
    logic                      overflowed;
  } rot_result_t;

  logic clk;
  logic rst_n;

  crm_in_if  in_ch ();
  crm_out_if out_ch ();

  cyclic_rotation_matcher_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  crm_pkg::elem_t ref_ring [crm_pkg::MAX_LEN];
  crm_pkg::elem_t cand_ring[crm_pkg::MAX_LEN];
  int             held_pairs;
  logic           dropped_pair;
  rot_result_t    pending_results[$];

  int idle_pct;
  int stall_pct;
  int items_sent;
  int errors;
  int quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.elem_a    = '0;
    in_ch.elem_b    = '0;
    in_ch.last_pair = 1'b0;
    out_ch.ready    = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    items_sent      = 0;
    errors          = 0;
    held_pairs      = 0;
    dropped_pair    = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // smallest offset k with cand[i] == ref[(k+i) mod len] for all i
  function automatic rot_result_t search_rotation(int len, logic ovf);
    rot_result_t res;
    int          idx;
    bit          hit;
    res.shift_offset = crm_pkg::NO_MATCH;
    res.overflowed   = ovf;
    for (int k = 0; k < len; k++) begin
      hit = 1'b1;
      idx = k;
      for (int i = 0; i < len; i++) begin
        if (ref_ring[idx] != cand_ring[i]) begin
          hit = 1'b0;
          break;
        end
        idx = (idx + 1 == len) ? 0 : idx + 1;
      end
      if (hit) begin
        res.shift_offset = crm_pkg::OFS_W'(k);
        break;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      if (held_pairs < crm_pkg::MAX_LEN) begin
        ref_ring[held_pairs]  = in_ch.elem_a[crm_pkg::ELEM_W-1:0];
        cand_ring[held_pairs] = in_ch.elem_b[crm_pkg::ELEM_W-1:0];
        held_pairs++;
      end else begin
        dropped_pair = 1'b1;
      end
      if (in_ch.last_pair) begin
        pending_results.push_back(search_rotation(held_pairs, dropped_pair));
        held_pairs   = 0;
        dropped_pair = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rot_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: offset=%0d overflowed=%b",
                   $signed(out_ch.shift_offset), out_ch.overflowed);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.shift_offset !== want.shift_offset ||
            out_ch.overflowed !== want.overflowed) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("mismatch: offset exp=%0d got=%0d, overflowed exp=%b got=%b",
                     $signed(want.shift_offset), $signed(out_ch.shift_offset),
                     want.overflowed, out_ch.overflowed);
        end
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_pair(input logic [crm_pkg::DATA_W-1:0] a,
                           input logic [crm_pkg::DATA_W-1:0] b,
                           input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.elem_a    <= a;
    in_ch.elem_b    <= b;
    in_ch.last_pair <= last;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  function automatic logic [crm_pkg::DATA_W-1:0] rand_elem(int pool);
    logic [crm_pkg::DATA_W-1:0] v;
    case (pool)
      0: v = $urandom;
      1: v = crm_pkg::DATA_W'($urandom_range(3));
      default: begin
        case ($urandom_range(3))
          0: v = ELEM_MIN;
          1: v = ELEM_MAX;
          2: v = '1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_sequence(int len, seq_kind_t kind);
    logic [crm_pkg::DATA_W-1:0] a_vals[];
    logic [crm_pkg::DATA_W-1:0] b_vals[];
    int                         stored;
    int                         k;
    int                         pool;
    a_vals = new[len];
    b_vals = new[len];
    stored = (len > crm_pkg::MAX_LEN) ? crm_pkg::MAX_LEN : len;
    pool   = $urandom_range(2);
    for (int i = 0; i < len; i++) begin
      a_vals[i] = rand_elem(pool);
      b_vals[i] = rand_elem(pool);
    end
    if (kind != SEQ_UNRELATED) begin
      k = $urandom_range(stored - 1);
      for (int i = 0; i < stored; i++)
        b_vals[i] = a_vals[(k + i) % stored];
      if (kind == SEQ_CORRUPTED)
        b_vals[$urandom_range(stored - 1)][$urandom_range(crm_pkg::DATA_W - 1)] ^= 1'b1;
    end
    for (int i = 0; i < len; i++)
      send_pair(a_vals[i], b_vals[i], i == len - 1);
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_pair(ELEM_MIN, ELEM_MIN, 1'b1);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b1);
    send_pair(ELEM_MAX, ELEM_MIN, 1'b0);
    send_pair(ELEM_MIN, ELEM_MAX, 1'b1);
    send_pair('0, '1, 1'b0);
    send_pair('1, '1, 1'b0);
    send_pair('0, '0, 1'b1);
    // periodic sequence: the smallest of several offsets must win
    send_pair(32'd1, 32'd2, 1'b0);
    send_pair(32'd2, 32'd1, 1'b0);
    send_pair(32'd1, 32'd2, 1'b0);
    send_pair(32'd2, 32'd1, 1'b1);
    send_pair(32'd5, 32'd8, 1'b0);
    send_pair(32'd6, 32'd9, 1'b0);
    send_pair(32'd7, 32'd5, 1'b0);
    send_pair(32'd8, 32'd6, 1'b0);
    send_pair(32'd9, 32'd7, 1'b1);
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_storage_full();
    idle_pct  = 0;
    stall_pct = 0;
    send_sequence(crm_pkg::MAX_LEN, SEQ_ROTATED);
    send_sequence(crm_pkg::MAX_LEN + 1, SEQ_ROTATED);
    send_sequence(crm_pkg::MAX_LEN + 6, SEQ_CORRUPTED);
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_random(int idle, int stall, int n_items);
    int stop_at;
    int r;
    int len;
    idle_pct  = idle;
    stall_pct = stall;
    stop_at   = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 70)
        len = $urandom_range(12, 1);
      else if (r < 92)
        len = $urandom_range(40, 13);
      else
        len = $urandom_range(crm_pkg::MAX_LEN + 4, crm_pkg::MAX_LEN - 4);
      r = $urandom_range(99);
      if (r < 60)
        send_sequence(len, SEQ_ROTATED);
      else if (r < 85)
        send_sequence(len, SEQ_CORRUPTED);
      else
        send_sequence(len, SEQ_UNRELATED);
    end
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_storage_full();
    test_random(0, 0, 220);
    test_random(58, 0, 220);
    test_random(0, 58, 220);
    test_random(28, 28, 220);

    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
